/* hw/rtl/ctt_pkg.sv */
// shared types and constants of the configuration transaction tracker
package ctt_pkg;

  typedef enum logic [1:0] {
    ModeSubmit = 2'd0,
    ModeTick   = 2'd1,
    ModeSent   = 2'd2,
    ModeAck    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhSendDue  = 3'd1,
    PhAwaitAck = 3'd2,
    PhRbDue    = 3'd3,
    PhAwaitRb  = 3'd4,
    PhResolved = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    OcPending   = 3'd0,
    OcUnknown   = 3'd1,
    OcAbandoned = 3'd2,
    OcAcked     = 3'd3,
    OcRbOk      = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    ActNone     = 2'd0,
    ActSend     = 2'd1,
    ActResolve  = 2'd2,
    ActReadback = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegAckTimeout      = 2'd0,
    RegReadbackTimeout = 2'd1,
    RegGetallOp        = 2'd2
  } reg_idx_e;

  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned TimeoutW  = 31;
  localparam int unsigned OpW       = 4;
  localparam int unsigned CountW    = 6;

  localparam logic [TimeoutW-1:0] AckTimeoutRst      = 31'd2000;
  localparam logic [TimeoutW-1:0] ReadbackTimeoutRst = 31'd10000;
  localparam logic [OpW-1:0]      GetallOpRst        = 4'd0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [15:0] node_id;
    logic [15:0] seq_value;
    logic [7:0]  ctx_id;
    logic [3:0]  job_op;
    logic        rb_job;
    logic [5:0]  entry_count;
    logic        more_pending;
    logic [1:0]  persist_code;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        accepted;
    logic [15:0] dest_node;
    logic [15:0] out_seq;
    logic [7:0]  out_ctx;
    logic [2:0]  outcome;
    logic [3:0]  out_op;
    logic [1:0]  persist;
    logic [5:0]  staged_total;
    logic        state_update;
  } rsp_t;

  typedef struct packed {
    logic [TimeoutW-1:0] ack_timeout;
    logic [TimeoutW-1:0] readback_timeout;
    logic [OpW-1:0]      getall_op_code;
  } cfg_t;

endpackage

/* hw/rtl/ctt_regs.sv */
// configuration register file behind the apb port
module ctt_regs import ctt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegAckTimeout:      cfg_d.ack_timeout      = pwdata[TimeoutW-1:0];
        RegReadbackTimeout: cfg_d.readback_timeout = pwdata[TimeoutW-1:0];
        RegGetallOp:        cfg_d.getall_op_code   = pwdata[OpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAckTimeout:      prdata = DataW'(cfg_q.ack_timeout);
      RegReadbackTimeout: prdata = DataW'(cfg_q.readback_timeout);
      RegGetallOp:        prdata = DataW'(cfg_q.getall_op_code);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout      <= AckTimeoutRst;
      cfg_q.readback_timeout <= ReadbackTimeoutRst;
      cfg_q.getall_op_code   <= GetallOpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/ctt_fifo.sv */
// small register queue used between front and back and at the result side
module ctt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/ctt_engine.sv */
// transaction state machine: takes one queued request a cycle unless rsp_full_i, and builds its result
module ctt_engine import ctt_pkg::*; #(
  parameter int unsigned MAX_STAGED       = 32,
  parameter int unsigned MAX_ACK_MESSAGES = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  req_valid_i,
  input  req_t  req_i,
  output logic  req_pop_o,
  input  logic  rsp_full_i,
  output logic  rsp_push_o,
  output rsp_t  rsp_o
);

  localparam int unsigned EntW = $clog2(MAX_STAGED + 1);
  localparam int unsigned MsgW = $clog2(MAX_ACK_MESSAGES + 1);
  localparam int unsigned SumW = ((EntW > CountW) ? EntW : CountW) + 1;

  phase_e          phase_q, phase_d;
  logic [15:0]     dest_q, dest_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [15:0]     seq_q, seq_d;
  logic [7:0]      ctx_q, ctx_d;
  outcome_e        outcome_q, outcome_d;
  logic [1:0]      persist_q, persist_d;
  logic [EntW-1:0] entries_q, entries_d;
  logic [MsgW-1:0] msgs_q, msgs_d;
  logic [31:0]     first_q, first_d;
  logic            first_vld_q, first_vld_d;
  logic [31:0]     window_q, window_d;

  logic                fire;
  logic [31:0]         start, diff;
  logic [TimeoutW-1:0] limit;
  logic                timed_out;
  logic                ack_ok;
  logic [SumW-1:0]     sum, ent_wide;

  assign fire       = req_valid_i && !rsp_full_i;
  assign req_pop_o  = fire;
  assign rsp_push_o = fire;

  // wrap-safe timeout: the difference read as signed must be non-negative
  always_comb begin
    if (phase_q == PhAwaitRb) begin
      start = first_vld_q ? first_q : window_q;
      limit = cfg_i.readback_timeout;
    end else begin
      start = window_q;
      limit = cfg_i.ack_timeout;
    end
    diff      = req_i.now_ms - start;
    timed_out = !diff[31] && (diff[30:0] >= limit);
  end

  always_comb begin
    phase_d     = phase_q;
    dest_d      = dest_q;
    op_d        = op_q;
    seq_d       = seq_q;
    ctx_d       = ctx_q;
    outcome_d   = outcome_q;
    persist_d   = persist_q;
    entries_d   = entries_q;
    msgs_d      = msgs_q;
    first_d     = first_q;
    first_vld_d = first_vld_q;
    window_d    = window_q;
    ack_ok      = 1'b0;
    sum         = SumW'(entries_q) + SumW'(req_i.entry_count);
    ent_wide    = SumW'(entries_q);
    rsp_o       = '0;

    case (mode_e'(req_i.mode))
      ModeSubmit: begin
        if (phase_q == PhIdle) begin
          dest_d      = req_i.node_id;
          op_d        = req_i.rb_job ? cfg_i.getall_op_code : req_i.job_op;
          ctx_d       = req_i.ctx_id;
          seq_d       = req_i.seq_value;
          outcome_d   = OcPending;
          persist_d   = '0;
          entries_d   = '0;
          msgs_d      = '0;
          first_d     = '0;
          first_vld_d = 1'b0;
          window_d    = req_i.now_ms;
          phase_d     = req_i.rb_job ? PhRbDue : PhSendDue;
          rsp_o.accepted = 1'b1;
        end
      end
      ModeTick: begin
        case (phase_q)
          PhSendDue: begin
            rsp_o.action  = ActSend;
            rsp_o.out_seq = seq_q;
            rsp_o.out_ctx = ctx_q;
          end
          PhAwaitAck: begin
            if (timed_out) begin
              outcome_d     = OcUnknown;
              persist_d     = '0;
              phase_d       = PhRbDue;
              rsp_o.action  = ActResolve;
              rsp_o.outcome = OcUnknown;
              rsp_o.out_op  = op_q;
            end
          end
          PhRbDue: begin
            rsp_o.action = ActReadback;
          end
          PhAwaitRb: begin
            if (timed_out) begin
              entries_d     = '0;
              msgs_d        = '0;
              outcome_d     = OcAbandoned;
              phase_d       = PhIdle;
              rsp_o.action  = ActResolve;
              rsp_o.outcome = OcAbandoned;
              rsp_o.out_op  = cfg_i.getall_op_code;
            end
          end
          PhResolved: begin
            phase_d            = PhIdle;
            rsp_o.action       = ActResolve;
            rsp_o.outcome      = outcome_q;
            rsp_o.out_op       = (outcome_q == OcRbOk) ? cfg_i.getall_op_code : op_q;
            rsp_o.persist      = persist_q;
            rsp_o.staged_total = ent_wide[CountW-1:0];
            rsp_o.state_update = (outcome_q == OcRbOk) || (outcome_q == OcAcked);
          end
          default: ;
        endcase
      end
      ModeSent: begin
        window_d = req_i.now_ms;
        if (phase_q == PhSendDue) begin
          phase_d = PhAwaitAck;
        end else if (phase_q == PhRbDue) begin
          first_d     = '0;
          first_vld_d = 1'b0;
          phase_d     = PhAwaitRb;
        end
      end
      ModeAck: begin
        ack_ok = ((phase_q == PhAwaitAck) || (phase_q == PhAwaitRb))
                 && (req_i.node_id == dest_q);
        if (phase_q == PhAwaitAck && req_i.seq_value != seq_q) begin
          ack_ok = 1'b0;
        end
        if (ack_ok && phase_q == PhAwaitRb && !first_vld_d) begin
          first_d     = req_i.now_ms;
          first_vld_d = 1'b1;
        end
        if (ack_ok && msgs_q < MsgW'(MAX_ACK_MESSAGES)) begin
          msgs_d    = msgs_q + 1'b1;
          entries_d = (sum > SumW'(MAX_STAGED)) ? EntW'(MAX_STAGED) : EntW'(sum);
          persist_d = req_i.persist_code;
          if (req_i.more_pending) begin
            if (!first_vld_d) begin
              first_d     = req_i.now_ms;
              first_vld_d = 1'b1;
            end
          end else begin
            outcome_d = (phase_q == PhAwaitAck) ? OcAcked : OcRbOk;
            phase_d   = PhResolved;
          end
        end
      end
      default: ;
    endcase

    rsp_o.dest_node = dest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      dest_q      <= '0;
      op_q        <= '0;
      seq_q       <= '0;
      ctx_q       <= '0;
      outcome_q   <= OcPending;
      persist_q   <= '0;
      entries_q   <= '0;
      msgs_q      <= '0;
      first_q     <= '0;
      first_vld_q <= 1'b0;
      window_q    <= '0;
    end else if (fire) begin
      phase_q     <= phase_d;
      dest_q      <= dest_d;
      op_q        <= op_d;
      seq_q       <= seq_d;
      ctx_q       <= ctx_d;
      outcome_q   <= outcome_d;
      persist_q   <= persist_d;
      entries_q   <= entries_d;
      msgs_q      <= msgs_d;
      first_q     <= first_d;
      first_vld_q <= first_vld_d;
      window_q    <= window_d;
    end
  end

endmodule

/* hw/rtl/config_transaction_tracker.sv */
// top level of the configuration transaction tracker
//
// requests enter through a queue port: a request is taken at a clock edge with
// push high and full low. each request is one event (submit, tick, sent or
// acknowledgement) and gives exactly one result. results leave through a second
// queue port: the oldest result sits on rsp_o while empty is low and is taken
// at an edge with pop high.
// a taken request lands in a front queue; the back engine retires one request
// per cycle from its head into the result queue while that queue has room, so
// throughput is one request per cycle; the result is registered in that queue.
// when the receiver stops popping, the result queue fills, the engine halts,
// the front queue fills behind it and full rises; nothing is lost.
// the user sets the timeout and get-all op code registers over the apb port
// (bytes 0, 4, 8) while no request is in flight; the block does not enforce it.
// reset empties both queues, returns the transaction to idle with all tracked
// fields cleared and loads the register defaults (2000 ms, 10000 ms, op 0).
module config_transaction_tracker import ctt_pkg::*; #(
  parameter int unsigned MAX_STAGED       = 32,
  parameter int unsigned MAX_ACK_MESSAGES = 8,
  parameter int unsigned FIFO_DEPTH       = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  req_t             req_i,
  output logic             empty,
  input  logic             pop,
  output rsp_t             rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  req_t head_req;
  rsp_t eng_rsp;
  logic req_empty, req_pop, rsp_full, rsp_push;
  logic [$bits(req_t)-1:0] head_bits;
  logic [$bits(rsp_t)-1:0] rsp_bits;

  ctt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctt_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (req_i),
    .full_o  (full),
    .pop_i   (req_pop),
    .data_o  (head_bits),
    .empty_o (req_empty)
  );

  assign head_req = req_t'(head_bits);

  ctt_engine #(
    .MAX_STAGED       (MAX_STAGED),
    .MAX_ACK_MESSAGES (MAX_ACK_MESSAGES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (!req_empty),
    .req_i       (head_req),
    .req_pop_o   (req_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (eng_rsp)
  );

  ctt_fifo #(
    .WIDTH ($bits(rsp_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (eng_rsp),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_bits),
    .empty_o (empty)
  );

  assign rsp_o = rsp_t'(rsp_bits);

endmodule

/* hw/rtl/ctt_checker.sv */
// port-level checks of the configuration transaction tracker and their binding
module ctt_checker import ctt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input rsp_t rsp_i,
  input logic pready
);

  // resolve-only fields stay clear on any other action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_i.action != ActResolve) |->
      (rsp_i.outcome == '0 && rsp_i.out_op == '0 && rsp_i.persist == '0
       && rsp_i.staged_total == '0 && rsp_i.state_update == 1'b0))
    else $error("resolve fields set without a resolve");

  // a taken submit never carries an action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_i.accepted) |-> (rsp_i.action == ActNone))
    else $error("accepted submit with an action");

  // state update only for a good outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_i.state_update) |->
      (rsp_i.outcome == OcAcked || rsp_i.outcome == OcRbOk))
    else $error("state update with a bad outcome");

  // a waiting result holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_i)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind config_transaction_tracker ctt_checker u_ctt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .rsp_i  (rsp_o),
  .pready (pready)
);
